### hdl/nrpe_pkg.sv
// Shared types, character codes and prefix table for the RMC position extractor.
package nrpe_pkg;

  localparam int unsigned PREFIX_LEN = 6;
  localparam int unsigned CC_W       = 7;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam logic [CC_W-1:0] CC_MAX = {CC_W{1'b1}};

  // Comma counts that select the fields of interest
  localparam logic [CC_W-1:0] FLD_STATUS = 7'd2;
  localparam logic [CC_W-1:0] FLD_LAT    = 7'd3;
  localparam logic [CC_W-1:0] FLD_LON    = 7'd5;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LAT  = 2'd1,
    KIND_LON  = 2'd2
  } char_kind_t;

  typedef struct packed {
    logic       fix_valid;
    logic       sentence_done;
    logic [7:0] char_value;
    char_kind_t char_kind;
  } result_t;

  // "$GPRMC", one character per position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### hdl/nrpe_parse.sv
// Sentence tracking state and per-character decode.
module nrpe_parse #(
  parameter int unsigned MAX_LINE  = 99,
  parameter int unsigned MAX_FIELD = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output logic            has_result,
  output nrpe_pkg::result_t result
);
  import nrpe_pkg::*;

  localparam int unsigned LPW = $clog2(MAX_LINE);
  localparam int unsigned FW  = $clog2(MAX_FIELD + 1);

  localparam logic [LPW-1:0] POS_LAST   = LPW'(MAX_LINE - 1);
  localparam logic [LPW-1:0] POS_PREFIX = LPW'(PREFIX_LEN);
  localparam logic [FW-1:0]  FIELD_LIM  = FW'(MAX_FIELD);

  logic            in_sentence_r, in_sentence_nxt;
  logic [LPW-1:0]  line_pos_r, line_pos_nxt;
  logic            prefix_ok_r, prefix_ok_nxt;
  logic [CC_W-1:0] comma_count_r, comma_count_nxt;
  logic            stopped_r, stopped_nxt;
  logic [FW-1:0]   lat_len_r, lat_len_nxt;
  logic [FW-1:0]   lon_len_r, lon_len_nxt;

  logic is_nl, last_byte, in_prefix, body, done;

  always_comb begin
    in_sentence_nxt = in_sentence_r;
    line_pos_nxt    = line_pos_r;
    prefix_ok_nxt   = prefix_ok_r;
    comma_count_nxt = comma_count_r;
    stopped_nxt     = stopped_r;
    lat_len_nxt     = lat_len_r;
    lon_len_nxt     = lon_len_r;
    result          = '0;
    done            = 1'b0;

    is_nl     = (rx_byte == CH_NL);
    last_byte = is_nl || (line_pos_r >= POS_LAST);
    in_prefix = (line_pos_r < POS_PREFIX);
    body      = 1'b0;

    if (!in_sentence_r) begin
      // Hunt for the start of a sentence
      if (rx_byte == CH_DOLLAR) begin
        in_sentence_nxt = 1'b1;
        line_pos_nxt    = LPW'(1);
        prefix_ok_nxt   = 1'b1;
        comma_count_nxt = '0;
        stopped_nxt     = 1'b0;
        lat_len_nxt     = '0;
        lon_len_nxt     = '0;
      end
    end else begin
      if (in_prefix && rx_byte != prefix_char(line_pos_r[2:0])) begin
        prefix_ok_nxt = 1'b0;
      end
      body = prefix_ok_nxt && !in_prefix && !is_nl && !stopped_r;

      if (body) begin
        priority if (rx_byte == CH_COMMA) begin
          if (comma_count_r != CC_MAX) comma_count_nxt = comma_count_r + 1'b1;
        end else if (comma_count_r == FLD_STATUS) begin
          if (rx_byte == CH_V) stopped_nxt = 1'b1;
        end else if (comma_count_r == FLD_LAT) begin
          if (lat_len_r < FIELD_LIM) begin
            lat_len_nxt       = lat_len_r + 1'b1;
            result.char_kind  = KIND_LAT;
            result.char_value = rx_byte;
          end
        end else if (comma_count_r == FLD_LON) begin
          if (lon_len_r < FIELD_LIM) begin
            lon_len_nxt       = lon_len_r + 1'b1;
            result.char_kind  = KIND_LON;
            result.char_value = rx_byte;
          end
        end else begin
          // other fields: skip
        end
      end

      if (last_byte) begin
        done            = prefix_ok_nxt && !in_prefix;
        in_sentence_nxt = 1'b0;
        line_pos_nxt    = '0;
      end else begin
        line_pos_nxt = line_pos_r + 1'b1;
      end
    end

    result.sentence_done = done;
    result.fix_valid     = done && !stopped_nxt;
    has_result           = done || (result.char_kind != KIND_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      line_pos_r    <= '0;
      prefix_ok_r   <= 1'b1;
      comma_count_r <= '0;
      stopped_r     <= 1'b0;
      lat_len_r     <= '0;
      lon_len_r     <= '0;
    end else if (step) begin
      in_sentence_r <= in_sentence_nxt;
      line_pos_r    <= line_pos_nxt;
      prefix_ok_r   <= prefix_ok_nxt;
      comma_count_r <= comma_count_nxt;
      stopped_r     <= stopped_nxt;
      lat_len_r     <= lat_len_nxt;
      lon_len_r     <= lon_len_nxt;
    end
  end

endmodule

### hdl/nrpe_out_reg.sv
// Result register that drives the outgoing stream.
module nrpe_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  nrpe_pkg::result_t load_data,
  input  logic              take,
  output logic              free,
  output logic              valid,
  output nrpe_pkg::result_t data
);
  import nrpe_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign free  = !valid_r || take;
  assign valid = valid_r;
  assign data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b0;
    if (load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

endmodule

### hdl/nmea_rmc_position_extractor_core.sv
// Top level of the NMEA RMC position extractor.
//
// Usage:
//   in_*  : one received serial character per transfer (in_tdata).
//   out_* : one result per transfer: a latitude or longitude character
//           and/or the end-of-sentence marker with the fix validity.
//   Bytes outside "$GPRMC" sentences, commas and other fields give no
//   result; a byte is consumed without any output transfer then.
// Path: an input transfer lands in the input register, then decodes into
//   the result register once that register has room, and shows on out_*.
// Throughput: one byte per cycle, sustained, while the receiver keeps
//   out_tready high. The running counters and flags of the sentence are
//   updated once per byte as it advances, which sets this rate.
// Stall: when out_tready is low the result register holds its result and
//   the input register still takes one more byte; only then does
//   in_tready drop. Bytes that produce no result keep flowing regardless.
// Reset: rst_n low (synchronous) empties both registers and returns the
//   parser to hunting for '$'.
module nmea_rmc_position_extractor_core #(
  parameter int unsigned MAX_LINE  = 99,
  parameter int unsigned MAX_FIELD = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] char_value
  output logic       out_tlast,  // sentence_done
  output logic [2:0] out_tuser   // [1:0] char_kind, [2] fix_valid
);
  import nrpe_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  logic    has_result;
  result_t parse_res;
  logic    out_free;
  logic    advance;
  logic    out_valid;
  result_t out_res;

  // Advance the held byte when its result (if any) finds room downstream
  assign advance   = in_valid_r && (!has_result || out_free);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (advance) in_valid_nxt = 1'b0;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // Payload: capture on every input transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_byte_r <= in_tdata;
  end

  nrpe_parse #(
    .MAX_LINE  (MAX_LINE),
    .MAX_FIELD (MAX_FIELD)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (in_byte_r),
    .has_result (has_result),
    .result     (parse_res)
  );

  nrpe_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && has_result),
    .load_data (parse_res),
    .take      (out_tready),
    .free      (out_free),
    .valid     (out_valid),
    .data      (out_res)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = out_res.char_value;
  assign out_tlast  = out_res.sentence_done;
  assign out_tuser  = {out_res.fix_valid, out_res.char_kind};

`ifndef SYNTHESIS
  // Every result carries a character or the end marker
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast || out_tuser[1:0] != 2'd0))
    else $error("empty result presented");

  // Fix validity only travels with the end marker
  a_fix_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> out_tlast)
    else $error("fix_valid without sentence_done");

  // Kind code three is never produced
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] != 2'd3)
    else $error("bad char_kind");

  // No character means a zero data byte
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] == 2'd0) |-> out_tdata == 8'd0)
    else $error("char_value set without a character");

  // A byte with a pending result is held while the result register is full
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && has_result && out_valid && !out_tready) |=> in_valid_r)
    else $error("input byte dropped while output stalled");
`endif

endmodule
